/* src/cbu_pkg.sv */
// Package: block size, character and config codes, the cube-face source map and the decode for the unscrambler.
package cbu_pkg;

  localparam int BLOCK_BYTES = 54;
  localparam int POS_W = 6;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_BANG = 8'd33;
  localparam logic [7:0] CH_DEL = 8'd127;

  localparam logic CFG_SHIFT_KEY = 1'b0;
  localparam logic CFG_MOVE_SELECT = 1'b1;

  typedef logic [7:0] byte_t;
  typedef logic [POS_W-1:0] pos_t;

  function automatic pos_t cbu_src(input logic [3:0] row, input pos_t pos);
    pos_t r;
    r = pos;
    case (row)
      4'd0: case (pos)
        6'd3: r = 6'd13;  6'd4: r = 6'd25;  6'd5: r = 6'd37;  6'd13: r = 6'd48;
        6'd19: r = 6'd5;  6'd25: r = 6'd49; 6'd31: r = 6'd4;  6'd37: r = 6'd50;
        6'd43: r = 6'd3;  6'd48: r = 6'd43; 6'd49: r = 6'd31; 6'd50: r = 6'd19;
        default: r = pos;
      endcase
      4'd1: case (pos)
        6'd3: r = 6'd43;  6'd4: r = 6'd31;  6'd5: r = 6'd19;  6'd13: r = 6'd3;
        6'd19: r = 6'd50; 6'd25: r = 6'd4;  6'd31: r = 6'd49; 6'd37: r = 6'd5;
        6'd43: r = 6'd48; 6'd48: r = 6'd13; 6'd49: r = 6'd25; 6'd50: r = 6'd37;
        default: r = pos;
      endcase
      4'd2: case (pos)
        6'd1: r = 6'd16;  6'd4: r = 6'd28;  6'd7: r = 6'd40;  6'd10: r = 6'd7;
        6'd16: r = 6'd52; 6'd22: r = 6'd4;  6'd28: r = 6'd49; 6'd34: r = 6'd1;
        6'd40: r = 6'd46; 6'd46: r = 6'd10; 6'd49: r = 6'd22; 6'd52: r = 6'd34;
        default: r = pos;
      endcase
      4'd3: case (pos)
        6'd1: r = 6'd34;  6'd4: r = 6'd22;  6'd7: r = 6'd10;  6'd10: r = 6'd46;
        6'd16: r = 6'd1;  6'd22: r = 6'd49; 6'd28: r = 6'd4;  6'd34: r = 6'd52;
        6'd40: r = 6'd7;  6'd46: r = 6'd40; 6'd49: r = 6'd28; 6'd52: r = 6'd16;
        default: r = pos;
      endcase
      4'd4: case (pos)
        6'd33: r = 6'd36; 6'd34: r = 6'd37; 6'd35: r = 6'd38; 6'd36: r = 6'd39;
        6'd37: r = 6'd40; 6'd38: r = 6'd41; 6'd39: r = 6'd42; 6'd40: r = 6'd43;
        6'd41: r = 6'd44; 6'd42: r = 6'd33; 6'd43: r = 6'd34; 6'd44: r = 6'd35;
        6'd45: r = 6'd51; 6'd46: r = 6'd48; 6'd47: r = 6'd45; 6'd48: r = 6'd52;
        6'd50: r = 6'd46; 6'd51: r = 6'd53; 6'd52: r = 6'd50; 6'd53: r = 6'd47;
        default: r = pos;
      endcase
      4'd5: case (pos)
        6'd33: r = 6'd42; 6'd34: r = 6'd43; 6'd35: r = 6'd44; 6'd36: r = 6'd33;
        6'd37: r = 6'd34; 6'd38: r = 6'd35; 6'd39: r = 6'd36; 6'd40: r = 6'd37;
        6'd41: r = 6'd38; 6'd42: r = 6'd39; 6'd43: r = 6'd40; 6'd44: r = 6'd41;
        6'd45: r = 6'd47; 6'd46: r = 6'd50; 6'd47: r = 6'd53; 6'd48: r = 6'd46;
        6'd50: r = 6'd52; 6'd51: r = 6'd45; 6'd52: r = 6'd48; 6'd53: r = 6'd51;
        default: r = pos;
      endcase
      4'd6: case (pos)
        6'd0: r = 6'd2;   6'd1: r = 6'd5;   6'd2: r = 6'd8;   6'd3: r = 6'd1;
        6'd5: r = 6'd7;   6'd6: r = 6'd0;   6'd7: r = 6'd3;   6'd8: r = 6'd6;
        6'd9: r = 6'd12;  6'd10: r = 6'd13; 6'd11: r = 6'd14; 6'd12: r = 6'd15;
        6'd13: r = 6'd16; 6'd14: r = 6'd17; 6'd15: r = 6'd18; 6'd16: r = 6'd19;
        6'd17: r = 6'd20; 6'd18: r = 6'd9;  6'd19: r = 6'd10; 6'd20: r = 6'd11;
        default: r = pos;
      endcase
      4'd7: case (pos)
        6'd0: r = 6'd6;   6'd1: r = 6'd3;   6'd2: r = 6'd0;   6'd3: r = 6'd7;
        6'd5: r = 6'd1;   6'd6: r = 6'd8;   6'd7: r = 6'd5;   6'd8: r = 6'd2;
        6'd9: r = 6'd18;  6'd10: r = 6'd19; 6'd11: r = 6'd20; 6'd12: r = 6'd9;
        6'd13: r = 6'd10; 6'd14: r = 6'd11; 6'd15: r = 6'd12; 6'd16: r = 6'd13;
        6'd17: r = 6'd14; 6'd18: r = 6'd15; 6'd19: r = 6'd16; 6'd20: r = 6'd17;
        default: r = pos;
      endcase
      4'd8: case (pos)
        6'd6: r = 6'd14;  6'd7: r = 6'd26;  6'd8: r = 6'd38;  6'd14: r = 6'd51;
        6'd15: r = 6'd39; 6'd16: r = 6'd27; 6'd17: r = 6'd15; 6'd18: r = 6'd8;
        6'd26: r = 6'd52; 6'd27: r = 6'd40; 6'd29: r = 6'd16; 6'd30: r = 6'd7;
        6'd38: r = 6'd53; 6'd39: r = 6'd41; 6'd40: r = 6'd29; 6'd41: r = 6'd17;
        6'd42: r = 6'd6;  6'd51: r = 6'd42; 6'd52: r = 6'd30; 6'd53: r = 6'd18;
        default: r = pos;
      endcase
      4'd9: case (pos)
        6'd6: r = 6'd42;  6'd7: r = 6'd30;  6'd8: r = 6'd18;  6'd14: r = 6'd6;
        6'd15: r = 6'd17; 6'd16: r = 6'd29; 6'd17: r = 6'd41; 6'd18: r = 6'd53;
        6'd26: r = 6'd7;  6'd27: r = 6'd16; 6'd29: r = 6'd40; 6'd30: r = 6'd52;
        6'd38: r = 6'd8;  6'd39: r = 6'd15; 6'd40: r = 6'd27; 6'd41: r = 6'd39;
        6'd42: r = 6'd51; 6'd51: r = 6'd14; 6'd52: r = 6'd26; 6'd53: r = 6'd38;
        default: r = pos;
      endcase
      4'd10: case (pos)
        6'd0: r = 6'd12;  6'd1: r = 6'd24;  6'd2: r = 6'd36;  6'd9: r = 6'd11;
        6'd10: r = 6'd23; 6'd11: r = 6'd35; 6'd12: r = 6'd45; 6'd20: r = 6'd2;
        6'd21: r = 6'd10; 6'd23: r = 6'd34; 6'd24: r = 6'd46; 6'd32: r = 6'd1;
        6'd33: r = 6'd9;  6'd34: r = 6'd21; 6'd35: r = 6'd33; 6'd36: r = 6'd47;
        6'd44: r = 6'd0;  6'd45: r = 6'd44; 6'd46: r = 6'd32; 6'd47: r = 6'd20;
        default: r = pos;
      endcase
      4'd11: case (pos)
        6'd0: r = 6'd44;  6'd1: r = 6'd32;  6'd2: r = 6'd20;  6'd9: r = 6'd33;
        6'd10: r = 6'd21; 6'd11: r = 6'd9;  6'd12: r = 6'd0;  6'd20: r = 6'd47;
        6'd21: r = 6'd34; 6'd23: r = 6'd10; 6'd24: r = 6'd1;  6'd32: r = 6'd46;
        6'd33: r = 6'd35; 6'd34: r = 6'd23; 6'd35: r = 6'd11; 6'd36: r = 6'd2;
        6'd44: r = 6'd45; 6'd45: r = 6'd12; 6'd46: r = 6'd24; 6'd47: r = 6'd36;
        default: r = pos;
      endcase
      4'd12: case (pos)
        6'd2: r = 6'd15;  6'd5: r = 6'd27;  6'd8: r = 6'd39;  6'd11: r = 6'd8;
        6'd12: r = 6'd14; 6'd13: r = 6'd26; 6'd14: r = 6'd38; 6'd15: r = 6'd51;
        6'd23: r = 6'd5;  6'd24: r = 6'd13; 6'd26: r = 6'd37; 6'd27: r = 6'd48;
        6'd35: r = 6'd2;  6'd36: r = 6'd12; 6'd37: r = 6'd24; 6'd38: r = 6'd36;
        6'd39: r = 6'd45; 6'd45: r = 6'd11; 6'd48: r = 6'd23; 6'd51: r = 6'd35;
        default: r = pos;
      endcase
      4'd13: case (pos)
        6'd2: r = 6'd35;  6'd5: r = 6'd23;  6'd8: r = 6'd11;  6'd11: r = 6'd45;
        6'd12: r = 6'd36; 6'd13: r = 6'd24; 6'd14: r = 6'd12; 6'd15: r = 6'd2;
        6'd23: r = 6'd48; 6'd24: r = 6'd37; 6'd26: r = 6'd13; 6'd27: r = 6'd5;
        6'd35: r = 6'd51; 6'd36: r = 6'd38; 6'd37: r = 6'd26; 6'd38: r = 6'd14;
        6'd39: r = 6'd8;  6'd45: r = 6'd39; 6'd48: r = 6'd27; 6'd51: r = 6'd15;
        default: r = pos;
      endcase
      4'd14: case (pos)
        6'd0: r = 6'd17;  6'd3: r = 6'd29;  6'd6: r = 6'd41;  6'd9: r = 6'd6;
        6'd17: r = 6'd53; 6'd18: r = 6'd42; 6'd19: r = 6'd30; 6'd20: r = 6'd18;
        6'd21: r = 6'd3;  6'd29: r = 6'd50; 6'd30: r = 6'd43; 6'd32: r = 6'd19;
        6'd33: r = 6'd0;  6'd41: r = 6'd47; 6'd42: r = 6'd44; 6'd43: r = 6'd32;
        6'd44: r = 6'd20; 6'd47: r = 6'd9;  6'd50: r = 6'd21; 6'd53: r = 6'd33;
        default: r = pos;
      endcase
      4'd15: case (pos)
        6'd0: r = 6'd33;  6'd3: r = 6'd21;  6'd6: r = 6'd9;   6'd9: r = 6'd47;
        6'd17: r = 6'd0;  6'd18: r = 6'd20; 6'd19: r = 6'd32; 6'd20: r = 6'd44;
        6'd21: r = 6'd50; 6'd29: r = 6'd3;  6'd30: r = 6'd19; 6'd32: r = 6'd43;
        6'd33: r = 6'd53; 6'd41: r = 6'd6;  6'd42: r = 6'd18; 6'd43: r = 6'd30;
        6'd44: r = 6'd42; 6'd47: r = 6'd41; 6'd50: r = 6'd29; 6'd53: r = 6'd17;
        default: r = pos;
      endcase
      default: r = pos;
    endcase
    return r;
  endfunction

  function automatic byte_t cbu_decode(input byte_t b, input byte_t key);
    byte_t v;
    v = (b == CH_BANG) ? CH_DEL : b;
    return (b == CH_NEWLINE) ? b : byte_t'(v - key);
  endfunction

endpackage

/* src/cbu_in_if.sv */
// Interface: input byte channel with valid/ready handshake.
interface cbu_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic end_of_stream;
  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

/* src/cbu_out_if.sv */
// Interface: result byte channel with valid/ready handshake.
interface cbu_out_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic last_of_run;
  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

/* src/cbu_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module cbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 54
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/cube_block_unscramble.sv */
// Top level: collects 54-byte blocks, unpermutes them and emits shift-decoded bytes.
//  channel | dir | payload                     | handshake
//  in_s    | in  | data_byte[8], end_of_stream | valid/ready
//  out_m   | out | out_byte[8], last_of_run    | valid/ready
//  cfg     | in  | cfg_index[1], cfg_data[8]   | cfg_we, no wait
// Filling accepts one byte per cycle. A full block then emits each byte after
// 8 steps through the shared source-map unit, a RAM read and the output state;
// a flushed partial block skips the steps. The input is not ready during a run.
// Reset is synchronous; a stalled output holds its beat.
module cube_block_unscramble (
  input  logic       clk,
  input  logic       rst_n,
  cbu_in_if.sink     in_s,
  cbu_out_if.source  out_m,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import cbu_pkg::*;

  localparam logic [1:0] ST_FILL  = 2'd0;
  localparam logic [1:0] ST_TRACE = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;
  localparam pos_t LAST_POS = pos_t'(BLOCK_BYTES - 1);

  logic [1:0] st_r, st_nxt;
  pos_t fill_r, fill_nxt;
  pos_t idx_r, idx_nxt;
  pos_t end_r, end_nxt;
  pos_t pos_r, pos_nxt;
  logic [2:0] stage_r, stage_nxt;
  logic perm_r, perm_nxt;
  byte_t key_r, msel_r;
  byte_t rdata;
  logic in_acc, out_acc;

  assign in_acc = in_s.valid && in_s.ready;
  assign out_acc = out_m.valid && out_m.ready;
  assign in_s.ready = (st_r == ST_FILL);
  assign out_m.valid = (st_r == ST_OUT);
  assign out_m.out_byte = cbu_decode(rdata, key_r);
  assign out_m.last_of_run = (idx_r == end_r);

  cbu_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (fill_r),
    .wdata (in_s.data_byte),
    .raddr (pos_r),
    .rdata (rdata)
  );

  always_comb begin
    st_nxt = st_r;
    fill_nxt = fill_r;
    idx_nxt = idx_r;
    end_nxt = end_r;
    pos_nxt = pos_r;
    stage_nxt = stage_r;
    perm_nxt = perm_r;
    case (st_r)
      ST_FILL: begin
        if (in_acc) begin
          idx_nxt = '0;
          pos_nxt = '0;
          stage_nxt = 3'd7;
          end_nxt = fill_r;
          if (fill_r == LAST_POS) begin
            perm_nxt = 1'b1;
            st_nxt = ST_TRACE;
          end else if (in_s.end_of_stream) begin
            perm_nxt = 1'b0;
            st_nxt = ST_READ;
          end else begin
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      ST_TRACE: begin
        pos_nxt = cbu_src({stage_r, msel_r[stage_r]}, pos_r);
        stage_nxt = stage_r - 1'b1;
        if (stage_r == 3'd0) begin
          st_nxt = ST_READ;
        end
      end
      ST_READ: begin
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) begin
          if (idx_r == end_r) begin
            fill_nxt = '0;
            st_nxt = ST_FILL;
          end else begin
            idx_nxt = idx_r + 1'b1;
            pos_nxt = idx_r + 1'b1;
            stage_nxt = 3'd7;
            st_nxt = perm_r ? ST_TRACE : ST_READ;
          end
        end
      end
      default: st_nxt = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_FILL;
      fill_r <= '0;
      key_r <= '0;
      msel_r <= '0;
    end else begin
      st_r <= st_nxt;
      fill_r <= fill_nxt;
      if (cfg_we && cfg_index == CFG_SHIFT_KEY) begin
        key_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_MOVE_SELECT) begin
        msel_r <= cfg_data;
      end
    end
    idx_r <= idx_nxt;
    end_r <= end_nxt;
    pos_r <= pos_nxt;
    stage_r <= stage_nxt;
    perm_r <= perm_nxt;
  end
endmodule

/* src/cbu_checker.sv */
// Checker: port-level properties of the unscrambler, bound to the top level.
module cbu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready during a run");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled beat changed");

  a_resume: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("no return to fill after last beat");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready) else $error("bad state after reset");
endmodule

bind cube_block_unscramble cbu_checker u_cbu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .out_byte  (out_m.out_byte),
  .out_last  (out_m.last_of_run)
);

/* tb/sv/tb_cbu_chan_if.sv */
// Testbench-side channel interfaces are the RTL ones; this file holds the beat item types.
package tb_cbu_types_pkg;
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_beat_t;
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_beat_t;
endpackage

/* tb/sv/tb_cube_block_unscramble.sv */
// Testbench for cube_block_unscramble: directed and random streams checked against a predictor.
module tb_cube_block_unscramble;
  import cbu_pkg::*;
  import tb_cbu_types_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [7:0] cfg_data;

  cbu_in_if in_s();
  cbu_out_if out_m();

  cube_block_unscramble dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_s), .out_m(out_m),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // destination/source pairs per stage and direction
  int unsigned perm_pairs[16][40] = '{
    '{3,13, 4,25, 5,37, 13,48, 19,5, 25,49, 31,4, 37,50, 43,3, 48,43, 49,31, 50,19,
      99,99, 99,99, 99,99, 99,99, 99,99, 99,99, 99,99, 99,99},
    '{3,43, 4,31, 5,19, 13,3, 19,50, 25,4, 31,49, 37,5, 43,48, 48,13, 49,25, 50,37,
      99,99, 99,99, 99,99, 99,99, 99,99, 99,99, 99,99, 99,99},
    '{1,16, 4,28, 7,40, 10,7, 16,52, 22,4, 28,49, 34,1, 40,46, 46,10, 49,22, 52,34,
      99,99, 99,99, 99,99, 99,99, 99,99, 99,99, 99,99, 99,99},
    '{1,34, 4,22, 7,10, 10,46, 16,1, 22,49, 28,4, 34,52, 40,7, 46,40, 49,28, 52,16,
      99,99, 99,99, 99,99, 99,99, 99,99, 99,99, 99,99, 99,99},
    '{33,36, 34,37, 35,38, 36,39, 37,40, 38,41, 39,42, 40,43, 41,44, 42,33,
      43,34, 44,35, 45,51, 46,48, 47,45, 48,52, 50,46, 51,53, 52,50, 53,47},
    '{33,42, 34,43, 35,44, 36,33, 37,34, 38,35, 39,36, 40,37, 41,38, 42,39,
      43,40, 44,41, 45,47, 46,50, 47,53, 48,46, 50,52, 51,45, 52,48, 53,51},
    '{0,2, 1,5, 2,8, 3,1, 5,7, 6,0, 7,3, 8,6, 9,12, 10,13,
      11,14, 12,15, 13,16, 14,17, 15,18, 16,19, 17,20, 18,9, 19,10, 20,11},
    '{0,6, 1,3, 2,0, 3,7, 5,1, 6,8, 7,5, 8,2, 9,18, 10,19,
      11,20, 12,9, 13,10, 14,11, 15,12, 16,13, 17,14, 18,15, 19,16, 20,17},
    '{6,14, 7,26, 8,38, 14,51, 15,39, 16,27, 17,15, 18,8, 26,52, 27,40,
      29,16, 30,7, 38,53, 39,41, 40,29, 41,17, 42,6, 51,42, 52,30, 53,18},
    '{6,42, 7,30, 8,18, 14,6, 15,17, 16,29, 17,41, 18,53, 26,7, 27,16,
      29,40, 30,52, 38,8, 39,15, 40,27, 41,39, 42,51, 51,14, 52,26, 53,38},
    '{0,12, 1,24, 2,36, 9,11, 10,23, 11,35, 12,45, 20,2, 21,10, 23,34,
      24,46, 32,1, 33,9, 34,21, 35,33, 36,47, 44,0, 45,44, 46,32, 47,20},
    '{0,44, 1,32, 2,20, 9,33, 10,21, 11,9, 12,0, 20,47, 21,34, 23,10,
      24,1, 32,46, 33,35, 34,23, 35,11, 36,2, 44,45, 45,12, 46,24, 47,36},
    '{2,15, 5,27, 8,39, 11,8, 12,14, 13,26, 14,38, 15,51, 23,5, 24,13,
      26,37, 27,48, 35,2, 36,12, 37,24, 38,36, 39,45, 45,11, 48,23, 51,35},
    '{2,35, 5,23, 8,11, 11,45, 12,36, 13,24, 14,12, 15,2, 23,48, 24,37,
      26,13, 27,5, 35,51, 36,38, 37,26, 38,14, 39,8, 45,39, 48,27, 51,15},
    '{0,17, 3,29, 6,41, 9,6, 17,53, 18,42, 19,30, 20,18, 21,3, 29,50,
      30,43, 32,19, 33,0, 41,47, 42,44, 43,32, 44,20, 47,9, 50,21, 53,33},
    '{0,33, 3,21, 6,9, 9,47, 17,0, 18,20, 19,32, 20,44, 21,50, 29,3,
      30,19, 32,43, 33,53, 41,6, 42,18, 43,30, 44,42, 47,41, 50,29, 53,17}
  };

  logic [7:0] key_reg;
  logic [7:0] select_reg;
  logic [7:0] held_bytes[BLOCK_BYTES];
  int unsigned held_count;
  out_beat_t expected_bytes[$];

  int errors = 0;
  int beats_sent;
  int beats_seen = 0;
  int runs_seen = 0;
  longint cycle_count = 0;
  bit send_idle_on;
  bit recv_idle_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] unshift(input logic [7:0] b);
    logic [7:0] v;
    if (b == 8'd10) return b;
    v = (b == 8'd33) ? 8'd127 : b;
    return v - key_reg;
  endfunction

  task automatic push_run(input int unsigned count);
    out_beat_t e;
    for (int i = 0; i < count; i++) begin
      e.out_byte = unshift(held_bytes[i]);
      e.last_of_run = (i == count - 1);
      expected_bytes.push_back(e);
    end
  endtask

  task automatic predict_byte(input in_beat_t it);
    logic [7:0] snap[BLOCK_BYTES];
    int unsigned row;
    held_bytes[held_count] = it.data_byte;
    held_count++;
    if (held_count == BLOCK_BYTES) begin
      for (int s = 0; s < 8; s++) begin
        row = s * 2 + select_reg[s];
        snap = held_bytes;
        for (int p = 0; p < 20; p++)
          if (perm_pairs[row][2*p] < BLOCK_BYTES)
            held_bytes[perm_pairs[row][2*p]] = snap[perm_pairs[row][2*p+1]];
      end
      push_run(BLOCK_BYTES);
      held_count = 0;
    end else if (it.end_of_stream) begin
      push_run(held_count);
      held_count = 0;
    end
  endtask

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stall bursts, check each beat
  initial begin
    int stall;
    out_m.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (recv_idle_on && $urandom_range(0, 3) == 0) begin
        out_m.ready <= 1'b0;
        stall = $urandom_range(1, 14);
        repeat (stall) @(posedge clk);
      end
      out_m.ready <= 1'b1;
      @(posedge clk);
      if (out_m.valid && out_m.ready) begin
        out_beat_t e;
        beats_seen++;
        if (expected_bytes.size() == 0) begin
          report("unexpected beat", out_m.out_byte, 8'h00);
        end else begin
          e = expected_bytes.pop_front();
          if (out_m.out_byte !== e.out_byte) report("out_byte", out_m.out_byte, e.out_byte);
          if (out_m.last_of_run !== e.last_of_run)
            report("last_of_run", out_m.last_of_run, e.last_of_run);
          if (e.last_of_run) runs_seen++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    in_beat_t it;
    if (send_idle_on && $urandom_range(0, 4) == 0) begin
      in_s.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_s.valid <= 1'b1;
    in_s.data_byte <= b;
    in_s.end_of_stream <= eos;
    @(posedge clk);
    while (!in_s.ready) @(posedge clk);
    it.data_byte = b;
    it.end_of_stream = eos;
    predict_byte(it);
    beats_sent++;
  endtask

  task automatic drain_wait;
    in_s.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_SHIFT_KEY) key_reg = val;
    else select_reg = val;
  endtask

  task automatic random_byte(output logic [7:0] b);
    case ($urandom_range(0, 7))
      0: b = 8'd10;
      1: b = 8'd33;
      default: b = 8'($urandom_range(0, 255));
    endcase
  endtask

  task automatic test_directed;
    write_reg(CFG_SHIFT_KEY, 8'd0);
    write_reg(CFG_MOVE_SELECT, 8'd0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'd10, 1'b0);
    send_byte(8'd33, 1'b0);
    send_byte(8'h80, 1'b1);
    drain_wait();
    write_reg(CFG_SHIFT_KEY, 8'hff);
    send_byte(8'd33, 1'b0);
    send_byte(8'd10, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b1);
    drain_wait();
  endtask

  task automatic test_full_blocks;
    logic [7:0] b;
    logic [7:0] sel_list[4] = '{8'h00, 8'hff, 8'ha5, 8'h5a};
    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_MOVE_SELECT, sel_list[k]);
      write_reg(CFG_SHIFT_KEY, 8'(k * 37));
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        b = (k == 0) ? 8'(i) : 8'($urandom_range(0, 255));
        send_byte(b, (k == 3) && (i == BLOCK_BYTES - 1));
      end
      drain_wait();
    end
  endtask

  task automatic test_random(input int n_items);
    logic [7:0] b;
    int run;
    int done;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        drain_wait();
        write_reg(CFG_SHIFT_KEY, 8'($urandom_range(0, 255)));
        write_reg(CFG_MOVE_SELECT, 8'($urandom_range(0, 255)));
      end
      run = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : BLOCK_BYTES;
      for (int i = 0; i < run && done < n_items; i++) begin
        random_byte(b);
        send_byte(b, (i == run - 1) && (run != BLOCK_BYTES || $urandom_range(0, 1)));
        done++;
      end
    end
    drain_wait();
  endtask

  initial begin
    beats_sent = 0;
    held_count = 0;
    key_reg = 8'd0;
    select_reg = 8'd0;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = 8'd0;
    in_s.valid = 1'b0;
    in_s.data_byte = 8'd0;
    in_s.end_of_stream = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    test_full_blocks();
    test_random(150);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    test_random(55);
    drain_wait();
    $display("sent %0d bytes, checked %0d output bytes in %0d runs", beats_sent, beats_seen,
             runs_seen);
    $display("covered partial flushes, full blocks under varied keys and select patterns");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
